### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### design/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Sizes, word types and shared structs of the LFU key-value table.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int CAPACITY   = 16;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int STAMP_W    = 32;
  localparam int CAP_W      = 5;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int USED_W     = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (USED_W > CAP_W) ? USED_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [STAMP_W-1:0]    stamp_t;

  // Input word
  typedef struct packed {
    logic                    kind;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] store_value;
  } lfu_in_t;

  // Output word
  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } lfu_out_t;

  // One table entry (payload, valid bit kept apart)
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    count_t           count;
    stamp_t           stamp;
  } entry_t;

  // Write request into the entry store
  typedef struct packed {
    logic   en;
    idx_t   idx;
    entry_t ent;
  } wr_req_t;

  // Running victim candidate fed back to the scan unit
  typedef struct packed {
    logic   found;
    count_t count;
    stamp_t age;
  } best_t;

  // Verdict of the scan unit on one entry
  typedef struct packed {
    logic   match;
    logic   better;
    stamp_t age;
  } scan_t;

endpackage

### design/lfu_cache_table.sv
// Flow: no new input word is taken until the current one has been applied; the single compare unit
//   visits one entry per cycle, then the apply step applies the update and loads the output register.
//   A stalled result holds the apply step, and the input stays stalled meanwhile.
// Reset: rst_ni async active low; clears valid bits, stamp counter and control state,
//   and sets active capacity to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
// LFU cache table
// Fully associative key-value table, least-frequently-used replacement with
// oldest-stamp tiebreak, scanned sequentially through a shared compare unit.
// ----------------------------------------------------------------------------
module lfu_cache_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  lfu_pkg::lfu_in_t         in_data_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output lfu_pkg::lfu_out_t        out_data_o,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata_i
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e           state_q, state_d;
  idx_t             idx_q;
  logic [CAP_W-1:0] cap_q;
  stamp_t           stamp_q;
  lfu_in_t          item_q;

  // scan bookkeeping
  logic              hit_q;
  idx_t              hit_idx_q;
  logic [VAL_W-1:0]  hit_val_q;
  count_t            hit_cnt_q;
  logic [USED_W-1:0] used_q;
  logic              free_found_q;
  idx_t              free_idx_q;
  best_t             vic_q;
  idx_t              vic_idx_q;

  logic     out_valid_q;
  lfu_out_t out_data_q;

  logic     rd_valid;
  entry_t   rd_ent;
  scan_t    scan;
  wr_req_t  wr;

  logic in_acc, last_idx, commit, lim_zero, full, do_touch, do_ins;
  idx_t tgt_idx;
  logic tgt_ok;
  count_t cnt_inc;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign last_idx = (idx_q == IDX_W'(CAPACITY - 1));
  assign commit   = (state_q == ST_APPLY) && !(out_valid_q && out_stall_i);

  // Entry store and shared compare unit
  lfu_entry_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_valid_o (rd_valid),
    .rd_ent_o   (rd_ent),
    .wr_i       (wr)
  );

  lfu_scan_unit u_scan (
    .ent_valid_i (rd_valid),
    .ent_i       (rd_ent),
    .key_i       (item_q.lookup_key),
    .stamp_now_i (stamp_q),
    .best_i      (vic_q),
    .res_o       (scan)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_SCAN;
      ST_SCAN:  if (last_idx) state_d = ST_APPLY;
      ST_APPLY: if (commit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Update decision; limit is min(cap, CAPACITY), so full means either bound reached
  always_comb begin
    lim_zero = (cap_q == '0);
    full     = (CMP_W'(used_q) >= CMP_W'(cap_q)) ||
               (used_q == USED_W'(CAPACITY)) || !free_found_q;
    tgt_idx  = full ? vic_idx_q : free_idx_q;
    tgt_ok   = full ? vic_q.found : 1'b1;
    do_touch = hit_q && ((item_q.kind == KIND_GET) || !lim_zero);
    do_ins   = !hit_q && (item_q.kind == KIND_PUT) && !lim_zero && tgt_ok;
    cnt_inc  = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);

    wr.en        = commit && (do_touch || do_ins);
    wr.idx       = hit_q ? hit_idx_q : tgt_idx;
    wr.ent.key   = item_q.lookup_key;
    wr.ent.value = (item_q.kind == KIND_PUT) ? item_q.store_value : hit_val_q;
    wr.ent.count = do_ins ? COUNT_BITS'(1) : cnt_inc;
    wr.ent.stamp = stamp_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      cap_q        <= CAP_RESET;
      stamp_q      <= '0;
      hit_q        <= 1'b0;
      used_q       <= '0;
      free_found_q <= 1'b0;
      vic_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        idx_q        <= '0;
        hit_q        <= 1'b0;
        used_q       <= '0;
        free_found_q <= 1'b0;
        vic_q.found  <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        idx_q <= idx_q + IDX_W'(1);
        if (scan.match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (rd_valid) begin
          used_q <= used_q + USED_W'(1);
        end else begin
          free_found_q <= 1'b1;
        end
        // running victim: lowest count, then oldest
        if (scan.better) begin
          vic_q.found <= 1'b1;
          vic_q.count <= rd_ent.count;
          vic_q.age   <= scan.age;
        end
      end
      if (wr.en) begin
        stamp_q <= stamp_q + STAMP_W'(1);
      end
      // output register
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_SCAN) begin
      if (scan.match && !hit_q) begin
        hit_idx_q <= idx_q;
        hit_val_q <= rd_ent.value;
        hit_cnt_q <= rd_ent.count;
      end
      if (!rd_valid && !free_found_q) begin
        free_idx_q <= idx_q;
      end
      if (scan.better) begin
        vic_idx_q <= idx_q;
      end
    end
    if (commit) begin
      out_data_q.found <= hit_q;
      if (item_q.kind == KIND_PUT) begin
        out_data_q.read_value <= '0;
      end else if (hit_q) begin
        out_data_q.read_value <= hit_val_q;
      end else begin
        out_data_q.read_value <= '1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Assertions
  `include "assert_macros.svh"

  `ASSERT_PROP(a_accept_starts_scan, in_acc |=> (state_q == ST_SCAN && idx_q == '0), "scan did not start at entry zero")
  `ASSERT_PROP(a_stamp_only_on_apply, $past(state_q != ST_APPLY) |-> $stable(stamp_q), "stamp moved outside apply")
  `ASSERT_PROP(a_result_from_apply, $rose(out_valid_q) |-> $past(state_q == ST_APPLY), "result raised outside apply")
  `ASSERT_NEVER(a_used_bound, state_q == ST_APPLY && used_q > USED_W'(CAPACITY), "occupancy above capacity")

endmodule

### design/lfu_entry_store.sv
// ----------------------------------------------------------------------------
// LFU entry store
// Register file of entries with valid bits; one read and one write port.
// ----------------------------------------------------------------------------
module lfu_entry_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lfu_pkg::idx_t   rd_idx_i,
  output logic            rd_valid_o,
  output lfu_pkg::entry_t rd_ent_o,
  input  lfu_pkg::wr_req_t wr_i
);
  import lfu_pkg::*;

  logic [CAPACITY-1:0] valid_q;
  entry_t              ent_q [CAPACITY];

  // Valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ent_q[wr_i.idx] <= wr_i.ent;
    end
  end

  // Read port
  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_ent_o   = ent_q[rd_idx_i];

endmodule

### design/lfu_scan_unit.sv
// ----------------------------------------------------------------------------
// LFU scan unit
// Shared compare unit: key match and victim ranking for one entry per cycle.
// ----------------------------------------------------------------------------
module lfu_scan_unit (
  input  logic                    ent_valid_i,
  input  lfu_pkg::entry_t         ent_i,
  input  logic [lfu_pkg::KEY_W-1:0] key_i,
  input  lfu_pkg::stamp_t         stamp_now_i,
  input  lfu_pkg::best_t          best_i,
  output lfu_pkg::scan_t          res_o
);
  import lfu_pkg::*;

  stamp_t age;

  // Age wraps modulo the stamp width
  assign age = stamp_now_i - ent_i.stamp;

  always_comb begin
    res_o.age    = age;
    res_o.match  = ent_valid_i && (ent_i.key == key_i);
    // lower count wins; equal count goes to the strictly older entry
    res_o.better = ent_valid_i &&
                   (!best_i.found || (ent_i.count < best_i.count) ||
                    ((ent_i.count == best_i.count) && (age > best_i.age)));
  end

endmodule
